>>> design/sorted_multiset_counter_assert.svh
// Assertion macros for the sorted multiset counter checker.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef SORTED_MULTISET_COUNTER_ASSERT_SVH
`define SORTED_MULTISET_COUNTER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SMC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define SMC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/smc_pkg.sv
// Shared types and constants for the sorted multiset counter.
// No dependencies; compile first.
package smc_pkg;

	localparam int VALUE_BITS    = 32;
	localparam int LIMIT_BITS    = 16;
	localparam int RESULT_BITS   = 16;
	localparam int TOTAL_BITS    = 22;
	localparam int DISTINCT_BITS = 7;
	localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

	typedef enum logic [1:0] {
		OP_ADD         = 2'd0,
		OP_REMOVE_ONE  = 2'd1,
		OP_QUERY       = 2'd2,
		OP_REMOVE_MANY = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOK,
		S_APPLY
	} state_t;

	// Command broadcast to every cell in the apply cycle
	typedef enum logic [1:0] {
		CMD_HOLD,
		CMD_SET_COUNT,
		CMD_INSERT,
		CMD_DELETE
	} cell_cmd_t;

	typedef struct packed {
		logic      look;
		cell_cmd_t cmd;
	} cell_ctl_t;

	// Flags one cell shows to its right-hand neighbor
	typedef struct packed {
		logic occ;
		logic gt;
	} nbr_flags_t;

endpackage

>>> design/smc_in_if.sv
// Request channel of the sorted multiset counter.
// Depends on smc_pkg.
interface smc_in_if;
	import smc_pkg::*;

	logic                          valid;
	logic                          ready;
	op_t                           operation;
	logic signed [VALUE_BITS-1:0]  element;
	logic        [LIMIT_BITS-1:0]  remove_limit;

	modport source (output valid, operation, element, remove_limit, input ready);
	modport sink (input valid, operation, element, remove_limit, output ready);
endinterface

>>> design/smc_out_if.sv
// Response channel of the sorted multiset counter.
// Depends on smc_pkg.
interface smc_out_if;
	import smc_pkg::*;

	logic                        valid;
	logic                        ready;
	status_t                     status;
	logic [RESULT_BITS-1:0]      count_result;
	logic [TOTAL_BITS-1:0]       total_items;
	logic [DISTINCT_BITS-1:0]    distinct_entries;
	logic                        is_empty;

	modport source (output valid, status, count_result, total_items, distinct_entries,
		is_empty, input ready);
	modport sink (input valid, status, count_result, total_items, distinct_entries,
		is_empty, output ready);
endinterface

>>> design/smc_cell.sv
// One slot of the sorted table: value, count and compare flags.
// Depends on smc_pkg; instantiated in a row by sorted_multiset_counter.
module smc_cell #(
	parameter int COUNT_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  smc_pkg::cell_ctl_t                    ctl,
	input  logic signed [smc_pkg::VALUE_BITS-1:0] element,
	input  logic [COUNT_BITS-1:0]                 new_count,
	input  logic signed [smc_pkg::VALUE_BITS-1:0] left_value,
	input  logic [COUNT_BITS-1:0]                 left_count,
	input  smc_pkg::nbr_flags_t                   left_flags,
	input  logic signed [smc_pkg::VALUE_BITS-1:0] right_value,
	input  logic [COUNT_BITS-1:0]                 right_count,
	output logic signed [smc_pkg::VALUE_BITS-1:0] value,
	output logic [COUNT_BITS-1:0]                 count,
	output smc_pkg::nbr_flags_t                   flags,
	output logic                                  hit
);
	import smc_pkg::*;

	logic signed [VALUE_BITS-1:0] value_q;
	logic [COUNT_BITS-1:0]        count_q;
	logic                         hit_q;
	logic                         gt_q;
	logic                         ge_q;
	logic                         occ;
	logic                         ins_here;
	logic                         take_right;

	// An empty slot has count zero: live entries never sit at zero
	assign occ = |count_q;
	assign hit = occ && (value_q == element);

	// New value lands right after the last smaller-or-equal occupied slot
	assign ins_here   = left_flags.occ && !left_flags.gt && (!occ || gt_q);
	assign take_right = !occ || ge_q;

	assign value     = value_q;
	assign count     = count_q;
	assign flags.occ = occ;
	assign flags.gt  = gt_q;

	// Capture compare flags in the look cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
			gt_q  <= 1'b0;
			ge_q  <= 1'b0;
		end else if (ctl.look) begin
			hit_q <= hit;
			gt_q  <= occ && (value_q > element);
			ge_q  <= value_q >= element;
		end
	end

	// Update count: overwrite on hit, shift on insert or delete
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			unique case (ctl.cmd)
				CMD_HOLD: ;
				CMD_SET_COUNT: begin
					if (hit_q) count_q <= new_count;
				end
				CMD_INSERT: begin
					if (left_flags.gt) count_q <= left_count;
					else if (ins_here) count_q <= COUNT_BITS'(1);
				end
				CMD_DELETE: begin
					if (take_right) count_q <= right_count;
				end
			endcase
		end
	end

	// Move values alongside their counts
	always_ff @(posedge clk) begin
		unique case (ctl.cmd)
			CMD_HOLD, CMD_SET_COUNT: ;
			CMD_INSERT: begin
				if (left_flags.gt) value_q <= left_value;
				else if (ins_here) value_q <= element;
			end
			CMD_DELETE: begin
				if (take_right) value_q <= right_value;
			end
		endcase
	end
endmodule

>>> design/sorted_multiset_counter.sv
// Top level of the sorted multiset counter: sequencer, totals and cell row.
// Depends on smc_pkg, smc_in_if, smc_out_if and smc_cell.
//
// Usage:
//   req carries one operation per transaction (add, remove one, query, remove
//   many) with a signed element and a remove limit. rsp returns one result per
//   request: status, count, total occurrences, distinct entries, empty flag.
//   Values live in a row of CAPACITY cells kept in ascending order; every cell
//   compares the element at once, and insert or delete moves each cell's
//   content one place to its neighbor in the apply cycle.
// Timing:
//   A request takes a look cycle (parallel compare, count pick-up) and an
//   apply cycle (cell update, totals). The response is registered and becomes
//   valid when the apply cycle commits. The next request is taken in the apply
//   cycle, while the previous request commits.
// Reset:
//   arst_n empties the table and clears totals; no clearing pass is needed.
// Stall:
//   While a response waits on rsp.ready the apply cycle holds, the table is not
//   touched and req.ready stays low until the response slot frees up.
module sorted_multiset_counter #(
	parameter int CAPACITY   = 64,
	parameter int COUNT_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	smc_in_if.sink        req,
	smc_out_if.source     rsp
);
	import smc_pkg::*;

	localparam int DIST_BITS = $clog2(CAPACITY + 1);
	localparam int TAKE_BITS = (COUNT_BITS > LIMIT_BITS) ? COUNT_BITS : LIMIT_BITS;
	localparam int DIFF_BITS = (TAKE_BITS > TOTAL_BITS) ? TAKE_BITS : TOTAL_BITS;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	state_t state_q, state_nx;

	op_t                          op_q;
	logic signed [VALUE_BITS-1:0] elem_q;
	logic [LIMIT_BITS-1:0]        limit_q;
	logic                         found_q;
	logic [COUNT_BITS-1:0]        found_count_q;
	logic                         full_q;
	logic [TOTAL_BITS-1:0]        total_q, total_nx;
	logic [DIST_BITS-1:0]         dist_q, dist_nx;
	logic                         out_valid_q;
	status_t                      status_q, status_nx;
	logic [COUNT_BITS-1:0]        result_q, result_nx;

	logic                         accept;
	logic                         commit;
	cell_ctl_t                    ctl;
	cell_cmd_t                    cmd_nx;
	logic [COUNT_BITS-1:0]        new_count;
	logic                         found_now;
	logic [COUNT_BITS-1:0]        found_count_now;
	logic [TAKE_BITS-1:0]         take;
	logic [COUNT_BITS-1:0]        remain;
	logic [DIFF_BITS-1:0]         total_w;
	logic [DIFF_BITS-1:0]         take_w;
	logic [TOTAL_BITS-1:0]        total_inc;
	logic [TOTAL_BITS-1:0]        total_dec;

	logic signed [VALUE_BITS-1:0] cell_value [CAPACITY];
	logic [COUNT_BITS-1:0]        cell_count [CAPACITY];
	nbr_flags_t                   cell_flags [CAPACITY];
	logic [CAPACITY-1:0]          cell_hit;
	logic signed [VALUE_BITS-1:0] left_value [CAPACITY];
	logic [COUNT_BITS-1:0]        left_count [CAPACITY];
	nbr_flags_t                   left_flags [CAPACITY];
	logic signed [VALUE_BITS-1:0] right_value [CAPACITY];
	logic [COUNT_BITS-1:0]        right_count [CAPACITY];

	// Wire the row: each cell sees both neighbors, the ends see fixed edges
	for (genvar i = 0; i < CAPACITY; i++) begin : g_row
		if (i == 0) begin : g_first
			assign left_value[i] = '0;
			assign left_count[i] = '0;
			assign left_flags[i] = '{occ: 1'b1, gt: 1'b0};
		end else begin : g_inner_l
			assign left_value[i] = cell_value[i-1];
			assign left_count[i] = cell_count[i-1];
			assign left_flags[i] = cell_flags[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_value[i] = '0;
			assign right_count[i] = '0;
		end else begin : g_inner_r
			assign right_value[i] = cell_value[i+1];
			assign right_count[i] = cell_count[i+1];
		end

		smc_cell #(
			.COUNT_BITS (COUNT_BITS)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.element     (elem_q),
			.new_count   (new_count),
			.left_value  (left_value[i]),
			.left_count  (left_count[i]),
			.left_flags  (left_flags[i]),
			.right_value (right_value[i]),
			.right_count (right_count[i]),
			.value       (cell_value[i]),
			.count       (cell_count[i]),
			.flags       (cell_flags[i]),
			.hit         (cell_hit[i])
		);
	end

	// Pick up the matching count; at most one cell hits
	always_comb begin
		found_now       = 1'b0;
		found_count_now = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			found_now       = found_now | cell_hit[i];
			found_count_now = found_count_now | (cell_hit[i] ? cell_count[i] : '0);
		end
	end

	// Next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE:  if (req.valid) state_nx = S_LOOK;
			S_LOOK:  state_nx = S_APPLY;
			S_APPLY: if (commit) state_nx = req.valid ? S_LOOK : S_IDLE;
			default: state_nx = S_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		commit    = 1'b0;
		req.ready = 1'b0;
		ctl.look  = 1'b0;
		ctl.cmd   = CMD_HOLD;
		unique case (state_q)
			S_IDLE: req.ready = 1'b1;
			S_LOOK: ctl.look = 1'b1;
			S_APPLY: begin
				commit    = !out_valid_q || rsp.ready;
				req.ready = commit;
				ctl.cmd   = commit ? cmd_nx : CMD_HOLD;
			end
			default: ;
		endcase
	end

	assign accept = req.valid && req.ready;

	// Amount to take and the count that stays
	always_comb begin
		if (op_q == OP_REMOVE_ONE)
			take = TAKE_BITS'(1);
		else if (TAKE_BITS'(limit_q) < TAKE_BITS'(found_count_q))
			take = TAKE_BITS'(limit_q);
		else
			take = TAKE_BITS'(found_count_q);
		remain    = found_count_q - COUNT_BITS'(take);
		total_w   = DIFF_BITS'(total_q);
		take_w    = DIFF_BITS'(take);
		total_inc = (total_q == TOTAL_MAX) ? total_q : total_q + 1'b1;
		total_dec = (total_w > take_w) ? TOTAL_BITS'(total_w - take_w) : '0;
	end

	// Decide the table command and the result
	always_comb begin
		cmd_nx    = CMD_HOLD;
		status_nx = ST_OK;
		result_nx = '0;
		new_count = found_count_q;
		total_nx  = total_q;
		dist_nx   = dist_q;
		unique case (op_q) inside
			OP_ADD: begin
				if (found_q) begin
					if (found_count_q != COUNT_MAX) begin
						new_count = found_count_q + 1'b1;
						cmd_nx    = CMD_SET_COUNT;
						total_nx  = total_inc;
					end
					result_nx = new_count;
				end else if (full_q) begin
					status_nx = ST_FULL;
				end else begin
					cmd_nx    = CMD_INSERT;
					total_nx  = total_inc;
					dist_nx   = dist_q + 1'b1;
					result_nx = COUNT_BITS'(1);
				end
			end
			OP_QUERY: begin
				if (found_q) result_nx = found_count_q;
				else status_nx = ST_NOT_FOUND;
			end
			OP_REMOVE_ONE, OP_REMOVE_MANY: begin
				if (!found_q) begin
					status_nx = ST_NOT_FOUND;
				end else begin
					new_count = remain;
					total_nx  = total_dec;
					if (remain == '0) begin
						cmd_nx  = CMD_DELETE;
						dist_nx = dist_q - 1'b1;
					end else begin
						cmd_nx = CMD_SET_COUNT;
					end
					result_nx = (op_q == OP_REMOVE_ONE) ? remain : COUNT_BITS'(take);
				end
			end
			default: ;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			total_q     <= '0;
			dist_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (commit) begin
				total_q     <= total_nx;
				dist_q      <= dist_nx;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Hold the request and look results
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= req.operation;
			elem_q  <= req.element;
			limit_q <= req.remove_limit;
		end
		if (ctl.look) begin
			found_q       <= found_now;
			found_count_q <= found_count_now;
			full_q        <= cell_flags[CAPACITY-1].occ;
		end
		if (commit) begin
			status_q <= status_nx;
			result_q <= result_nx;
		end
	end

	// Drive the response; totals only change when a new response is loaded
	assign rsp.valid            = out_valid_q;
	assign rsp.status           = status_q;
	assign rsp.count_result     = RESULT_BITS'(result_q);
	assign rsp.total_items      = total_q;
	assign rsp.distinct_entries = DISTINCT_BITS'(dist_q);
	assign rsp.is_empty         = (dist_q == '0);
endmodule

>>> design/smc_checker.sv
// Port-level checks for the sorted multiset counter, bound to the top level.
// Depends on smc_pkg and sorted_multiset_counter_assert.svh.
`include "sorted_multiset_counter_assert.svh"

module smc_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 rsp_valid,
	input logic                                 rsp_ready,
	input smc_pkg::status_t                     status,
	input logic [smc_pkg::RESULT_BITS-1:0]      count_result,
	input logic [smc_pkg::TOTAL_BITS-1:0]       total_items,
	input logic [smc_pkg::DISTINCT_BITS-1:0]    distinct_entries,
	input logic                                 is_empty
);
	import smc_pkg::*;

	// Stalled response keeps its payload
	`SMC_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(status) && $stable(count_result) && $stable(total_items), "response changed while stalled")

	// Empty table carries no occurrences
	`SMC_ASSERT_IMP(a_empty_totals, rsp_valid && is_empty, distinct_entries == '0 && total_items == '0, "empty flag with nonzero totals")

	// Failed operations report a zero count
	`SMC_ASSERT_IMP(a_fail_zero, rsp_valid && (status == ST_NOT_FOUND || status == ST_FULL), count_result == '0, "failed operation with nonzero count")

	// Full table cannot be empty
	`SMC_ASSERT_IMP(a_full_nonempty, rsp_valid && status == ST_FULL, !is_empty, "full status on empty table")
endmodule

bind sorted_multiset_counter smc_checker u_smc_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.status           (rsp.status),
	.count_result     (rsp.count_result),
	.total_items      (rsp.total_items),
	.distinct_entries (rsp.distinct_entries),
	.is_empty         (rsp.is_empty)
);

>>> dv/testbench.sv
// Self-checking testbench for the sorted multiset counter.
// Depends on smc_pkg, smc_in_if, smc_out_if and sorted_multiset_counter.
`timescale 1ns / 1ps

module testbench;
	import smc_pkg::*;

	localparam int CAPACITY       = 64;
	localparam int COUNT_BITS     = 16;
	localparam int RANDOM_ITEMS   = 1300;
	localparam int POOL_SIZE      = 96;
	localparam int LONG_HOLD      = 300;
	localparam int WATCHDOG_LIMIT = 3000;

	// One expected response
	typedef struct {
		status_t                  status;
		logic [RESULT_BITS-1:0]   tally;
		logic [TOTAL_BITS-1:0]    total;
		logic [DISTINCT_BITS-1:0] distinct;
		logic                     empty;
	} smc_reply_t;

	// Tracks the multiset contents and the responses still owed by the block
	class multiset_tracker;
		localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_BITS) - 64'd1;
		localparam int unsigned TOTAL_CAP = (1 << TOTAL_BITS) - 1;

		int                held_value[CAPACITY];
		longint unsigned   held_count[CAPACITY];
		int                n_distinct;
		int unsigned       total_held;
		smc_reply_t        expected_q[$];
		int                errors;
		int                replies;

		function int pending();
			return expected_q.size();
		endfunction

		task report(string what);
			errors++;
			if (errors <= 50)
				$display("MISMATCH %s", what);
		endtask

		// Apply one accepted request to the tracked contents and queue its response
		function void note_request(op_t op, int elem, logic [LIMIT_BITS-1:0] limit);
			smc_reply_t      want;
			int              pos;
			int              ins;
			longint unsigned take;
			pos = -1;
			for (int i = 0; i < n_distinct; i++) begin
				if (held_value[i] == elem) begin
					pos = i;
					break;
				end
			end
			want.status = ST_OK;
			want.tally = '0;
			if (op == OP_ADD) begin
				if (pos >= 0) begin
					// saturate the count, total follows only on a real increase
					if (held_count[pos] < COUNT_MAX) begin
						held_count[pos]++;
						if (total_held < TOTAL_CAP)
							total_held++;
					end
					want.tally = RESULT_BITS'(held_count[pos]);
				end else if (n_distinct >= CAPACITY) begin
					want.status = ST_FULL;
				end else begin
					// insert in ascending position
					ins = 0;
					while (ins < n_distinct && held_value[ins] <= elem)
						ins++;
					for (int j = n_distinct; j > ins; j--) begin
						held_value[j] = held_value[j-1];
						held_count[j] = held_count[j-1];
					end
					held_value[ins] = elem;
					held_count[ins] = 64'd1;
					n_distinct++;
					if (total_held < TOTAL_CAP)
						total_held++;
					want.tally = RESULT_BITS'(1);
				end
			end else if (pos < 0) begin
				want.status = ST_NOT_FOUND;
			end else if (op == OP_QUERY) begin
				want.tally = RESULT_BITS'(held_count[pos]);
			end else begin
				take = (op == OP_REMOVE_ONE) ? 64'd1 : 64'(limit);
				if (take > held_count[pos])
					take = held_count[pos];
				held_count[pos] -= take;
				total_held = (64'(total_held) > take) ? total_held - 32'(take) : '0;
				want.tally = (op == OP_REMOVE_ONE) ? RESULT_BITS'(held_count[pos])
					: RESULT_BITS'(take);
				// close the gap when the count runs out
				if (held_count[pos] == 0) begin
					for (int j = pos; j + 1 < n_distinct; j++) begin
						held_value[j] = held_value[j+1];
						held_count[j] = held_count[j+1];
					end
					n_distinct--;
					held_count[n_distinct] = '0;
				end
			end
			want.total = TOTAL_BITS'(total_held);
			want.distinct = DISTINCT_BITS'(n_distinct);
			want.empty = (n_distinct == 0);
			expected_q.push_back(want);
		endfunction

		// Compare one response with the oldest expectation
		task check_response(status_t st, logic [RESULT_BITS-1:0] tally,
				logic [TOTAL_BITS-1:0] total, logic [DISTINCT_BITS-1:0] distinct,
				logic empty);
			smc_reply_t want;
			replies++;
			if (expected_q.size() == 0) begin
				report($sformatf("response %0d with no request outstanding", replies));
				return;
			end
			want = expected_q.pop_front();
			if (st !== want.status)
				report($sformatf("response %0d status %0d, want %0d", replies, st,
					want.status));
			if (tally !== want.tally)
				report($sformatf("response %0d count %0d, want %0d", replies, tally,
					want.tally));
			if (total !== want.total)
				report($sformatf("response %0d total %0d, want %0d", replies, total,
					want.total));
			if (distinct !== want.distinct)
				report($sformatf("response %0d distinct %0d, want %0d", replies, distinct,
					want.distinct));
			if (empty !== want.empty)
				report($sformatf("response %0d empty %0b, want %0b", replies, empty,
					want.empty));
		endtask
	endclass

	logic clk;
	logic arst_n;

	smc_in_if  req_if();
	smc_out_if rsp_if();

	sorted_multiset_counter #(
		.CAPACITY   (CAPACITY),
		.COUNT_BITS (COUNT_BITS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if.sink),
		.rsp    (rsp_if.source)
	);

	multiset_tracker tracker = new();

	bit idle_on;
	int long_hold_reqs;
	int quiet_cycles;
	int pool[POOL_SIZE];

	// Generate the clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Record accepted requests and check accepted responses
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_if.valid && req_if.ready)
				tracker.note_request(req_if.operation, req_if.element, req_if.remove_limit);
			if (rsp_if.valid && rsp_if.ready)
				tracker.check_response(rsp_if.status, rsp_if.count_result,
					rsp_if.total_items, rsp_if.distinct_entries, rsp_if.is_empty);
		end
	end

	// Count cycles with no transaction on either channel
	always @(posedge clk) begin
		if (!arst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= WATCHDOG_LIMIT);
		$display("TB_ERROR");
		$finish;
	end

	// Drive response ready: random stall bursts, plus one long hold on request
	initial begin
		int hold_left;
		int long_hold_done;
		hold_left = 0;
		long_hold_done = 0;
		rsp_if.ready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_left != 0) begin
				rsp_if.ready = 1'b0;
				hold_left--;
			end else if (long_hold_done != long_hold_reqs) begin
				long_hold_done++;
				hold_left = LONG_HOLD - 1;
				rsp_if.ready = 1'b0;
			end else if (idle_on && $urandom_range(0, 99) < 12) begin
				hold_left = $urandom_range(0, 15);
				rsp_if.ready = 1'b0;
			end else begin
				rsp_if.ready = 1'b1;
			end
		end
	end

	// Offer one request and hold it until accepted; called at a falling edge
	task automatic issue(op_t op, int elem, logic [LIMIT_BITS-1:0] limit);
		if (idle_on && $urandom_range(0, 99) < 10) begin
			req_if.valid = 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		req_if.valid = 1'b1;
		req_if.operation = op;
		req_if.element = elem;
		req_if.remove_limit = limit;
		do
			@(posedge clk);
		while (!req_if.ready);
		@(negedge clk);
	endtask

	// Stop offering and wait until every response has come back
	task automatic drain();
		req_if.valid = 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [LIMIT_BITS-1:0] pick_limit();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return '0;
		else if (r < 20)
			return '1;
		else if (r < 35)
			return LIMIT_BITS'($urandom);
		else
			return LIMIT_BITS'($urandom_range(1, 4));
	endfunction

	initial begin
		int  sat_value;
		int  slot;
		int  r;
		bit  grow;
		op_t op;

		arst_n = 1'b0;
		idle_on = 1'b1;
		long_hold_reqs = 0;
		req_if.valid = 1'b0;
		req_if.operation = OP_QUERY;
		req_if.element = '0;
		req_if.remove_limit = '0;
		pool[0] = 32'h8000_0000;
		pool[1] = 32'h7FFF_FFFF;
		pool[2] = 0;
		pool[3] = -1;
		for (int i = 4; i < POOL_SIZE; i++)
			pool[i] = $urandom;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty table, extremes, absent values, deletes down to empty
		issue(OP_QUERY, 0, 16'd0);
		issue(OP_ADD, 32'h8000_0000, 16'hFFFF);
		issue(OP_ADD, 32'h7FFF_FFFF, 16'd0);
		issue(OP_ADD, 0, 16'd7);
		issue(OP_ADD, -1, 16'd1);
		issue(OP_ADD, 0, 16'd2);
		issue(OP_QUERY, 0, 16'd0);
		issue(OP_QUERY, 5, 16'd0);
		issue(OP_REMOVE_ONE, 5, 16'd0);
		issue(OP_REMOVE_MANY, 5, 16'd3);
		issue(OP_REMOVE_MANY, 0, 16'd0);
		issue(OP_REMOVE_MANY, 0, 16'hFFFF);
		issue(OP_REMOVE_ONE, 32'h7FFF_FFFF, 16'd0);
		issue(OP_REMOVE_MANY, 32'h8000_0000, 16'd1);
		issue(OP_REMOVE_ONE, -1, 16'hFFFF);
		issue(OP_REMOVE_ONE, -1, 16'd0);

		// Pile up one value's count back to back, then clear it in one go
		idle_on = 1'b0;
		sat_value = $urandom;
		repeat (40)
			issue(OP_ADD, sat_value, LIMIT_BITS'($urandom));
		issue(OP_QUERY, sat_value, 16'd0);
		issue(OP_REMOVE_ONE, sat_value, 16'd0);
		issue(OP_ADD, sat_value, 16'd0);
		issue(OP_REMOVE_MANY, sat_value, 16'hFFFF);
		idle_on = 1'b1;

		// Fill every slot, then hit the full table with new and known values
		for (int i = 0; i < CAPACITY; i++)
			issue(OP_ADD, pool[i], pick_limit());
		issue(OP_ADD, pool[CAPACITY], 16'd0);
		issue(OP_QUERY, pool[CAPACITY], 16'd0);
		issue(OP_ADD, pool[10], 16'd0);

		// Random: alternate growing and shrinking stretches over a shared value pool
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == 400)
				long_hold_reqs++;
			if (i == 700)
				drain();
			if (i == RANDOM_ITEMS - 200)
				idle_on = 1'b0;
			grow = ((i / 150) % 2) == 1;
			r = $urandom_range(0, 99);
			if (grow)
				op = (r < 60) ? OP_ADD : (r < 75) ? OP_REMOVE_ONE
					: (r < 85) ? OP_QUERY : OP_REMOVE_MANY;
			else
				op = (r < 20) ? OP_ADD : (r < 55) ? OP_REMOVE_ONE
					: (r < 65) ? OP_QUERY : OP_REMOVE_MANY;
			// now and then replace a spare pool value with a fresh one
			if ($urandom_range(0, 99) < 3) begin
				slot = $urandom_range(CAPACITY, POOL_SIZE - 1);
				pool[slot] = $urandom;
			end else begin
				slot = $urandom_range(0, POOL_SIZE - 1);
			end
			issue(op, pool[slot], pick_limit());
		end

		// Wrap up: drain, let stray responses show, then judge
		drain();
		repeat (20) @(posedge clk);
		if (tracker.pending() != 0)
			tracker.report("requests left without a response");
		if (tracker.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
